>>> hw/rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, codes and the interval decode for the periodic endpoint
// scheduler.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int FrameW  = 14;
  localparam int IvW     = 16;
  localparam int BusyW   = 9;
  localparam int SlotW   = 4;
  localparam int EvW     = 4;
  localparam int MaxRes  = 16;
  localparam int ResCntW = 5;
  localparam logic [BusyW-1:0] BusyLimit = 9'd500;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_UNREG = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [EvW-1:0] {
    EV_START   = 4'd0,
    EV_SKIP    = 4'd1,
    EV_WRAP    = 4'd2,
    EV_REG     = 4'd3,
    EV_IVERR   = 4'd4,
    EV_FULL    = 4'd5,
    EV_REMOVED = 4'd6,
    EV_ABSENT  = 4'd7,
    EV_DONE    = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WALK   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  // One table entry as it travels along the chain
  typedef struct packed {
    logic             valid;
    logic [IvW-1:0]   interval;
    logic [IvW-1:0]   remain;
    logic [BusyW-1:0] busy;
    logic [BusyW-1:0] bmax;
  } entry_t;

  // Operation seen by the head of the chain
  typedef struct packed {
    kind_t             kind;
    logic [FrameW-1:0] cost;
    logic [IvW-1:0]    interval;
    logic              claim;
    logic              match;
  } head_op_t;

  // Tick result produced at the head
  typedef struct packed {
    logic             due;
    event_t           ev;
    logic [BusyW-1:0] peak;
  } head_res_t;

  // Decode the descriptor interval code; zero means invalid
  function automatic logic [IvW-1:0] decode_interval(logic hs, logic ib, logic [7:0] code);
    logic [IvW-1:0] v;
    v = '0;
    if (hs || !ib) begin
      if (code >= 8'd1 && code <= 8'd16) begin
        v = IvW'(1) << (code - 8'd1);
      end
    end else begin
      v = IvW'(code);
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/pes_cell.sv
// ----------------------------------------------------------------------------
// pes_cell
// One table entry of the scheduler ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module pes_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  pes_pkg::entry_t d,
  output pes_pkg::entry_t q
);
  import pes_pkg::*;

  entry_t ent_r;

  // Move the payload with the ring; clear the valid bit on reset
  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r.interval <= d.interval;
      ent_r.remain   <= d.remain;
      ent_r.busy     <= d.busy;
      ent_r.bmax     <= d.bmax;
    end
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift) begin
      ent_r.valid <= d.valid;
    end
  end

  assign q = ent_r;

endmodule

>>> hw/rtl/pes_head.sv
// ----------------------------------------------------------------------------
// pes_head
// Update logic for the entry at the head of the ring: countdown, reload,
// busy accounting, registration, removal and completion.
// ----------------------------------------------------------------------------
module pes_head (
  input  pes_pkg::entry_t   ent_i,
  input  pes_pkg::head_op_t op,
  output pes_pkg::entry_t   ent_o,
  output pes_pkg::head_res_t res
);
  import pes_pkg::*;

  logic [IvW-1:0]   cost_w;
  logic [BusyW:0]   busy_inc;
  logic [BusyW-1:0] bmax_new;

  assign cost_w   = IvW'(op.cost);
  assign busy_inc = {1'b0, ent_i.busy} + 10'd1;
  assign bmax_new = (BusyW'(busy_inc) > ent_i.bmax) ? BusyW'(busy_inc) : ent_i.bmax;

  always_comb begin
    ent_o = ent_i;
    res   = '{due: 1'b0, ev: EV_START, peak: '0};
    unique case (op.kind)
      KIND_TICK: begin
        if (ent_i.valid) begin
          if (ent_i.remain >= cost_w) begin
            // not due: count down
            ent_o.remain = ent_i.remain - cost_w;
          end else begin
            // due: reload, then start, skip or wrap
            res.due = 1'b1;
            if (cost_w > ent_i.interval) begin
              ent_o.remain = ent_i.interval;
            end else begin
              ent_o.remain = ent_i.remain + (ent_i.interval - cost_w);
            end
            if (ent_i.busy == '0) begin
              ent_o.busy = BusyW'(1);
              res.ev     = EV_START;
              res.peak   = ent_i.bmax;
            end else begin
              ent_o.bmax = bmax_new;
              res.peak   = bmax_new;
              if (busy_inc > {1'b0, BusyLimit}) begin
                ent_o.busy = BusyW'(1);
                res.ev     = EV_WRAP;
              end else begin
                ent_o.busy = BusyW'(busy_inc);
                res.ev     = EV_SKIP;
              end
            end
          end
        end
      end
      KIND_REG: begin
        if (op.claim) begin
          ent_o.valid    = 1'b1;
          ent_o.interval = op.interval;
          ent_o.remain   = op.interval;
          ent_o.busy     = '0;
          ent_o.bmax     = '0;
        end
      end
      KIND_UNREG: begin
        if (op.match) begin
          ent_o.valid = 1'b0;
        end
      end
      KIND_DONE: begin
        if (op.match) begin
          ent_o.busy = '0;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/periodic_endpoint_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_endpoint_scheduler
// Table of periodic endpoints kept in a ring of cells, walked once per word.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one command word (frame tick, register,
// unregister, completion). Each accepted word rotates the whole ring of
// MAX_ENTRIES cells once, one entry per cycle at the head cell unless the
// output stalls, then passes through a finishing state; in_stall is high
// during that time. The next word is accepted in the cycle after the finish.
// A tick yields one result word per due entry, in slot order, up to 16; the
// other commands yield exactly one. out_last marks the final result word.
// Results leave through one output register; one due result is held back so
// its last flag is known. While out_stall is high and the output register is
// full, the walk pauses, so the rate then follows the receiver.
// Reset clears all valid bits and the previous frame number, and the block
// is ready for a word in the first cycle after reset.
// ----------------------------------------------------------------------------
module periodic_endpoint_scheduler #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [pes_pkg::FrameW-1:0] in_frame_number,
  input  logic [3:0]                in_entry_slot,
  input  logic                      in_high_speed,
  input  logic                      in_interrupt_or_bulk,
  input  logic [7:0]                in_poll_code,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_slot,
  output logic [3:0]                out_event_res,
  output logic [8:0]                out_busy_peak,
  output logic                      out_last
);
  import pes_pkg::*;

  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMW = (IW > SlotW) ? IW : SlotW;

  state_t state_r, state_nxt;
  logic [IW-1:0]     cnt_r;
  kind_t             kind_r;
  logic [FrameW-1:0] frame_r, cost_r, prev_frame_r;
  logic [SlotW-1:0]  es_r;
  logic [IvW-1:0]    iv_r;
  logic              claimed_r, empty_r, found_r;
  logic [IW-1:0]     claim_idx_r;
  logic [BusyW-1:0]  found_peak_r;
  logic              pend_valid_r;
  logic [SlotW-1:0]  pend_slot_r;
  event_t            pend_ev_r;
  logic [BusyW-1:0]  pend_peak_r;
  logic [ResCntW-1:0] nres_r;
  logic              out_valid_r;
  logic [SlotW-1:0]  out_slot_r;
  event_t            out_ev_r;
  logic [BusyW-1:0]  out_peak_r;
  logic              out_last_r;

  entry_t    chain [MAX_ENTRIES];
  entry_t    head_new;
  head_op_t  op;
  head_res_t hres;

  logic in_acc, can_push, step, last_step, take_res;
  logic out_load;
  logic [SlotW-1:0] ld_slot;
  event_t           ld_ev;
  logic [BusyW-1:0] ld_peak;
  logic             ld_last;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign can_push  = !out_valid_r || !out_stall;
  assign step      = (state_r == ST_WALK) && can_push;
  assign last_step = (cnt_r == IW'(MAX_ENTRIES - 1));
  assign take_res  = step && hres.due && (nres_r < ResCntW'(MaxRes));

  // Head operation
  always_comb begin
    op.kind     = kind_r;
    op.cost     = cost_r;
    op.interval = iv_r;
    op.claim    = (iv_r != '0) && !claimed_r && !chain[0].valid;
    op.match    = chain[0].valid && (CMW'(es_r) == CMW'(cnt_r));
  end

  pes_head u_head (
    .ent_i (chain[0]),
    .op    (op),
    .ent_o (head_new),
    .res   (hres)
  );

  // Ring of cells, head at index 0
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    entry_t d_w;
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign d_w = head_new;
    end else begin : g_mid
      assign d_w = chain[k+1];
    end
    pes_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (step),
      .d     (d_w),
      .q     (chain[k])
    );
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and output load
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    ld_slot   = pend_slot_r;
    ld_ev     = pend_ev_r;
    ld_peak   = pend_peak_r;
    ld_last   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (take_res && pend_valid_r) out_load = 1'b1;
        if (step && last_step) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_push) begin
          state_nxt = ST_IDLE;
          ld_last   = 1'b1;
          unique case (kind_r)
            KIND_TICK: begin
              out_load = pend_valid_r;
            end
            KIND_REG: begin
              out_load = 1'b1;
              ld_peak  = '0;
              ld_slot  = claimed_r ? SlotW'(claim_idx_r) : '0;
              if (iv_r == '0) begin
                ld_ev   = EV_IVERR;
                ld_slot = '0;
              end else if (claimed_r) begin
                ld_ev = EV_REG;
              end else begin
                ld_ev = EV_FULL;
              end
            end
            KIND_UNREG, KIND_DONE: begin
              out_load = 1'b1;
              ld_slot  = es_r;
              ld_peak  = found_r ? found_peak_r : '0;
              if (!found_r) begin
                ld_ev = EV_ABSENT;
              end else if (kind_r == KIND_UNREG) begin
                ld_ev = EV_REMOVED;
              end else begin
                ld_ev = EV_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      nres_r       <= '0;
      prev_frame_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r        <= '0;
        nres_r       <= '0;
        pend_valid_r <= 1'b0;
        if (kind_t'(in_kind) == KIND_TICK) begin
          prev_frame_r <= in_frame_number;
        end
      end
      if (step) cnt_r <= cnt_r + IW'(1);
      if (take_res) begin
        pend_valid_r <= 1'b1;
        nres_r       <= nres_r + ResCntW'(1);
      end
      if (state_r == ST_FINISH && can_push) begin
        pend_valid_r <= 1'b0;
        if (kind_r == KIND_REG && claimed_r && empty_r) prev_frame_r <= frame_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the command and collect walk status
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= kind_t'(in_kind);
      frame_r   <= in_frame_number;
      cost_r    <= in_frame_number - prev_frame_r;
      es_r      <= in_entry_slot;
      iv_r      <= decode_interval(in_high_speed, in_interrupt_or_bulk, in_poll_code);
      claimed_r <= 1'b0;
      empty_r   <= 1'b1;
      found_r   <= 1'b0;
    end else if (step) begin
      if (chain[0].valid) empty_r <= 1'b0;
      if (kind_r == KIND_REG && op.claim) begin
        claimed_r   <= 1'b1;
        claim_idx_r <= cnt_r;
      end
      if (op.match) begin
        found_r      <= 1'b1;
        found_peak_r <= chain[0].bmax;
      end
    end
  end

  // Hold back the newest tick result
  always_ff @(posedge clk) begin
    if (take_res) begin
      pend_slot_r <= SlotW'(cnt_r);
      pend_ev_r   <= hres.ev;
      pend_peak_r <= hres.peak;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r <= ld_slot;
      out_ev_r   <= ld_ev;
      out_peak_r <= ld_peak;
      out_last_r <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_event_res = out_ev_r;
  assign out_busy_peak = out_peak_r;
  assign out_last      = out_last_r;

  // No held result outside a command
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("held result left after command");

  // Result count never exceeds the limit
  a_nres: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= ResCntW'(MaxRes))
    else $error("too many results");

  // Output is never overwritten while stalled
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> can_push)
    else $error("output word overwritten");

  // Walk ends with the ring back in place
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> cnt_r == IW'(MAX_ENTRIES))
    else $error("walk count wrong");

endmodule
